// File: design/clr_pkg.sv
// shared types and constants of the clamped line raster core
// used by the controller, the datapath, the top level and the port checker
package clr_pkg;

   // fixed payload layout of the two stream channels
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 32;
   localparam int COORD_IN_W  = 16;
   localparam int COLOR_W     = 16;
   localparam int PIXEL_X_W   = 9;
   localparam int PIXEL_Y_W   = 8;
   localparam int INDEX_OUT_W = 8;
   localparam int RSP_USED_W  = PIXEL_X_W + PIXEL_Y_W + INDEX_OUT_W + 2;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_EMIT  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      DIR_ZERO = 2'b00,
      DIR_UP   = 2'b01,
      DIR_DOWN = 2'b11
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_HIT,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear;
      logic step;
      logic drop;
      logic setup;
      logic load_diff;
      logic scan_first;
      logic scan_next;
      logic finish_hit;
      logic finish_scan;
      logic finish_append;
   } cmd_type;

   typedef struct packed {
      logic dropped;
      logic match;
      logic scan_more;
      logic line_active;
      logic out_busy;
   } status_type;

endpackage

// File: design/clr_ctrl.sv
// sequencer of the clamped line raster core: request decode and palette search steps
// depends on clr_pkg for the state, opcode, command and status types
module clr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [1:0]         req_opcode,
   input  logic               rsp_tready,
   input  clr_pkg::status_type status,
   output logic               req_tready,
   output clr_pkg::cmd_type   cmd
);
   import clr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !status.out_busy || rsp_tready;
            if (req_tvalid && req_tready) begin
               unique case (req_opcode)
                  OP_START: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_SETUP;
                  end
                  OP_EMIT:  cmd.step  = status.line_active;
                  OP_CLEAR: cmd.clear = 1'b1;
                  default:  ;
               endcase
            end
         end
         ST_SETUP: begin
            if (status.dropped) begin
               cmd.drop = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = ST_HIT;
            end
         end
         ST_HIT: begin
            cmd.load_diff = 1'b1;
            if (status.match) begin
               cmd.finish_hit = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.scan_first = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.match) begin
               cmd.finish_scan = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.scan_more) begin
               cmd.scan_next = 1'b1;
            end else begin
               cmd.finish_append = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: design/clr_datapath.sv
// datapath of the clamped line raster core: clamp, line walk, palette memory, result register
// depends on clr_pkg for payload widths, direction codes, command and status types
module clr_datapath #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  clr_pkg::cmd_type                       cmd,
   input  logic signed [clr_pkg::COORD_IN_W-1:0]  req_start_x,
   input  logic signed [clr_pkg::COORD_IN_W-1:0]  req_start_y,
   input  logic signed [clr_pkg::COORD_IN_W-1:0]  req_end_x,
   input  logic signed [clr_pkg::COORD_IN_W-1:0]  req_end_y,
   input  logic [clr_pkg::COLOR_W-1:0]            req_line_color,
   input  logic                                   rsp_tready,
   output clr_pkg::status_type                    status,
   output logic                                   rsp_valid,
   output logic                                   rsp_pixel_valid,
   output logic [clr_pkg::PIXEL_X_W-1:0]          rsp_pixel_x,
   output logic [clr_pkg::PIXEL_Y_W-1:0]          rsp_pixel_y,
   output logic [clr_pkg::INDEX_OUT_W-1:0]        rsp_color_index,
   output logic                                   rsp_last_pixel,
   output logic                                   rsp_line_dropped,
   output logic                                   rsp_palette_full
);
   import clr_pkg::*;

   localparam int CX_W   = $clog2(SCREEN_WIDTH);
   localparam int CY_W   = $clog2(SCREEN_HEIGHT);
   localparam int LEN_W  = (CX_W > CY_W) ? CX_W : CY_W;
   localparam int ERR_W  = LEN_W + 3;
   localparam int CNT_W  = LEN_W + 1;
   localparam int IDX_W  = $clog2(PALETTE_DEPTH);
   localparam int USED_W = $clog2(PALETTE_DEPTH + 1);
   localparam logic signed [COORD_IN_W-1:0] X_LAST = COORD_IN_W'(SCREEN_WIDTH - 1);
   localparam logic signed [COORD_IN_W-1:0] Y_LAST = COORD_IN_W'(SCREEN_HEIGHT - 1);

   function automatic logic off_screen(logic signed [COORD_IN_W-1:0] v,
                                       logic signed [COORD_IN_W-1:0] last);
      return (v < 0) || (v > last);
   endfunction

   function automatic logic [COORD_IN_W-1:0] clamp_val(logic signed [COORD_IN_W-1:0] v,
                                                       logic signed [COORD_IN_W-1:0] last);
      logic [COORD_IN_W-1:0] r;
      if (v > last) r = last;
      else if (v < 0) r = '0;
      else r = v;
      return r;
   endfunction

   // captured endpoints
   logic [CX_W-1:0]    x1_ff, x2_ff;
   logic [CY_W-1:0]    y1_ff, y2_ff;
   logic               dropped_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [COORD_IN_W-1:0] x1_c, y1_c, x2_c, y2_c;
   logic               first_out, second_out;

   always_comb begin
      x1_c       = clamp_val(req_start_x, X_LAST);
      y1_c       = clamp_val(req_start_y, Y_LAST);
      x2_c       = clamp_val(req_end_x, X_LAST);
      y2_c       = clamp_val(req_end_y, Y_LAST);
      first_out  = off_screen(req_start_x, X_LAST) || off_screen(req_start_y, Y_LAST);
      second_out = off_screen(req_end_x, X_LAST) || off_screen(req_end_y, Y_LAST);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x1_ff      <= x1_c[CX_W-1:0];
         y1_ff      <= y1_c[CY_W-1:0];
         x2_ff      <= x2_c[CX_W-1:0];
         y2_ff      <= y2_c[CY_W-1:0];
         dropped_ff <= first_out && second_out;
         color_ff   <= req_line_color;
      end
   end

   // line setup
   logic [CX_W-1:0]  adx;
   logic [CY_W-1:0]  ady;
   logic [LEN_W-1:0] adx_l, ady_l, major_c, minor_c;
   logic             x_major_c;
   dir_type          dir_x_c, dir_y_c;

   always_comb begin
      adx = (x2_ff >= x1_ff) ? (x2_ff - x1_ff) : (x1_ff - x2_ff);
      ady = (y2_ff >= y1_ff) ? (y2_ff - y1_ff) : (y1_ff - y2_ff);
      if (x2_ff > x1_ff) dir_x_c = DIR_UP;
      else if (x2_ff < x1_ff) dir_x_c = DIR_DOWN;
      else dir_x_c = DIR_ZERO;
      if (y2_ff > y1_ff) dir_y_c = DIR_UP;
      else if (y2_ff < y1_ff) dir_y_c = DIR_DOWN;
      else dir_y_c = DIR_ZERO;
      adx_l     = LEN_W'(adx);
      ady_l     = LEN_W'(ady);
      x_major_c = adx_l >= ady_l;
      major_c   = x_major_c ? adx_l : ady_l;
      minor_c   = x_major_c ? ady_l : adx_l;
   end

   // walk state
   logic [CX_W-1:0]         cur_x_ff, cur_x_in;
   logic [CY_W-1:0]         cur_y_ff, cur_y_in;
   dir_type                 dir_x_ff, dir_y_ff;
   logic                    x_major_ff;
   logic [LEN_W-1:0]        major_ff, minor_ff;
   logic signed [ERR_W-1:0] err_ff, diff_ff;
   logic signed [ERR_W-1:0] err_a, err_b;
   logic [CNT_W-1:0]        left_ff;
   logic                    active_ff;
   logic                    minor_go, x_move, y_move;

   always_comb begin
      err_a    = err_ff + $signed({2'b00, minor_ff, 1'b0});
      err_b    = err_ff + diff_ff;
      minor_go = err_a >= $signed({3'b000, major_ff});
      x_move   = x_major_ff || minor_go;
      y_move   = !x_major_ff || minor_go;
      cur_x_in = cur_x_ff;
      if (x_move) begin
         case (dir_x_ff)
            DIR_UP:   cur_x_in = cur_x_ff + 1'b1;
            DIR_DOWN: cur_x_in = cur_x_ff - 1'b1;
            default:  cur_x_in = cur_x_ff;
         endcase
      end
      cur_y_in = cur_y_ff;
      if (y_move) begin
         case (dir_y_ff)
            DIR_UP:   cur_y_in = cur_y_ff + 1'b1;
            DIR_DOWN: cur_y_in = cur_y_ff - 1'b1;
            default:  cur_y_in = cur_y_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         cur_x_ff   <= x1_ff;
         cur_y_ff   <= y1_ff;
         dir_x_ff   <= dir_x_c;
         dir_y_ff   <= dir_y_c;
         x_major_ff <= x_major_c;
         major_ff   <= major_c;
         minor_ff   <= minor_c;
         err_ff     <= '0;
      end else if (cmd.step) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         err_ff   <= minor_go ? err_b : err_a;
      end
      // step to the minor axis folds the two updates into one add
      if (cmd.load_diff) begin
         diff_ff <= $signed({2'b00, minor_ff, 1'b0}) - $signed({2'b00, major_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         active_ff <= 1'b0;
      end else if (cmd.drop) begin
         left_ff   <= '0;
         active_ff <= 1'b0;
      end else if (cmd.setup) begin
         left_ff   <= CNT_W'(major_c) + 1'b1;
         active_ff <= 1'b1;
      end else if (cmd.step) begin
         left_ff <= left_ff - 1'b1;
         if (left_ff == CNT_W'(1)) begin
            active_ff <= 1'b0;
         end
      end
   end

   // palette: entries below the fill count are valid, entry 0 is always black
   logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rdata_ff;
   logic               rd_zero_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [COLOR_W-1:0] entry;
   logic [USED_W-1:0]  used_ff;
   logic [IDX_W-1:0]   last_hit_ff, scan_idx_ff, active_index_ff;
   logic               pal_full;
   logic [IDX_W-1:0]   found_idx;

   always_comb begin
      if (cmd.scan_first) rd_addr = '0;
      else if (cmd.scan_next) rd_addr = scan_idx_ff + 1'b1;
      else rd_addr = last_hit_ff;
      entry    = rd_zero_ff ? '0 : rdata_ff;
      pal_full = used_ff == USED_W'(PALETTE_DEPTH);
      if (cmd.finish_hit) found_idx = last_hit_ff;
      else if (cmd.finish_scan) found_idx = scan_idx_ff;
      else if (pal_full) found_idx = '0;
      else found_idx = used_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      rdata_ff   <= pal_mem[rd_addr];
      rd_zero_ff <= rd_addr == '0;
      if (cmd.finish_append && !pal_full) begin
         pal_mem[used_ff[IDX_W-1:0]] <= color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= USED_W'(1);
         last_hit_ff <= '0;
      end else if (cmd.clear) begin
         used_ff     <= USED_W'(1);
         last_hit_ff <= '0;
      end else if (cmd.finish_scan) begin
         last_hit_ff <= scan_idx_ff;
      end else if (cmd.finish_append && !pal_full) begin
         used_ff <= used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_first) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_next) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      if (cmd.finish_hit || cmd.finish_scan || cmd.finish_append) begin
         active_index_ff <= found_idx;
      end
   end

   // result register
   logic                   out_valid_ff;
   logic                   out_pix_ff, out_last_ff, out_drop_ff, out_full_ff;
   logic [PIXEL_X_W-1:0]   out_x_ff;
   logic [PIXEL_Y_W-1:0]   out_y_ff;
   logic [INDEX_OUT_W-1:0] out_idx_ff;
   logic                   status_load;

   assign status_load = cmd.finish_hit || cmd.finish_scan || cmd.finish_append;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.step || cmd.drop || status_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         out_pix_ff  <= 1'b1;
         out_x_ff    <= PIXEL_X_W'(cur_x_ff);
         out_y_ff    <= PIXEL_Y_W'(cur_y_ff);
         out_idx_ff  <= INDEX_OUT_W'(active_index_ff);
         out_last_ff <= left_ff == CNT_W'(1);
         out_drop_ff <= 1'b0;
         out_full_ff <= 1'b0;
      end else if (cmd.drop || status_load) begin
         out_pix_ff  <= 1'b0;
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_idx_ff  <= cmd.drop ? '0 : INDEX_OUT_W'(found_idx);
         out_last_ff <= 1'b0;
         out_drop_ff <= cmd.drop;
         out_full_ff <= cmd.finish_append && pal_full;
      end
   end

   always_comb begin
      status.dropped     = dropped_ff;
      status.match       = entry == color_ff;
      status.scan_more   = (USED_W'(scan_idx_ff) + USED_W'(1)) < used_ff;
      status.line_active = active_ff;
      status.out_busy    = out_valid_ff;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_valid  = out_pix_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_color_index  = out_idx_ff;
   assign rsp_last_pixel   = out_last_ff;
   assign rsp_line_dropped = out_drop_ff;
   assign rsp_palette_full = out_full_ff;

endmodule

// File: design/clamped_line_raster_with_palette_core.sv
// top level of the clamped line raster core with its color palette
// depends on clr_pkg, clr_ctrl and clr_datapath
//
// Rasterizes lines one pixel per emit transaction. Emits may follow each other in every
// cycle while the result side keeps taking transactions; emit with no line in progress
// and clear give no result. A start clamps both endpoints to the screen; when both
// needed clamping it answers with a dropped status. Otherwise the line color is looked
// up in the palette memory, which has one read port and yields one entry per cycle: the
// last matched entry is tried first, and on a miss the search reads the entries in use
// (at most PALETTE_DEPTH) in turn. New colors are appended; when the palette is full
// the line still draws with index 0 and the status flags it. The palette is tracked by
// a fill count, so reset and clear take effect at once with no sweep of the memory.
module clamped_line_raster_with_palette_core #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_x, start_y, end_x, end_y, line_color (16 bits each, lowest first)
   input  logic [clr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode
   input  logic [1:0]                        req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_x[8:0], pixel_y[16:9], color_index[24:17], line_dropped[25],
   // palette_full[26], zero fill above
   output logic [clr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // pixel_valid
   output logic                              rsp_tuser,
   // last_pixel
   output logic                              rsp_tlast
);
   import clr_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic signed [COORD_IN_W-1:0] start_x, start_y, end_x, end_y;
   logic [COLOR_W-1:0]           line_color;

   // unpack the request transaction
   assign start_x    = $signed(req_tdata[15:0]);
   assign start_y    = $signed(req_tdata[31:16]);
   assign end_x      = $signed(req_tdata[47:32]);
   assign end_y      = $signed(req_tdata[63:48]);
   assign line_color = req_tdata[79:64];

   logic                   dp_valid, dp_pix, dp_last, dp_drop, dp_full;
   logic [PIXEL_X_W-1:0]   dp_x;
   logic [PIXEL_Y_W-1:0]   dp_y;
   logic [INDEX_OUT_W-1:0] dp_idx;

   // sequencer: accepts only while idle and the result register is free or draining
   clr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   clr_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_start_x      (start_x),
      .req_start_y      (start_y),
      .req_end_x        (end_x),
      .req_end_y        (end_y),
      .req_line_color   (line_color),
      .rsp_tready       (rsp_tready),
      .status           (status),
      .rsp_valid        (dp_valid),
      .rsp_pixel_valid  (dp_pix),
      .rsp_pixel_x      (dp_x),
      .rsp_pixel_y      (dp_y),
      .rsp_color_index  (dp_idx),
      .rsp_last_pixel   (dp_last),
      .rsp_line_dropped (dp_drop),
      .rsp_palette_full (dp_full)
   );

   // pack the result transaction
   assign rsp_tvalid = dp_valid;
   assign rsp_tuser  = dp_pix;
   assign rsp_tlast  = dp_last;
   assign rsp_tdata  = RSP_TDATA_W'({dp_full, dp_drop, dp_idx, dp_y, dp_x});

endmodule

// File: design/clr_checker.sv
// port-level checks of the clamped line raster core, bound to the top level
// depends on clr_pkg for the opcode codes and channel widths
module clr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [1:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [clr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);
   import clr_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // pixels carry no start status flags
   a_pixel_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[25] && !rsp_tdata[26])
      else $error("status flag set on a pixel");

   // a dropped line reports index 0, no last flag and no full flag
   a_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |->
         rsp_tdata[24:17] == '0 && !rsp_tlast && !rsp_tuser && !rsp_tdata[26])
      else $error("dropped status malformed");

   // a status carries no coordinates and no last flag
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[16:0] == '0 && !rsp_tlast)
      else $error("status carries pixel fields");

   // a palette clear produces no result
   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_CLEAR
         && !(rsp_tvalid && !rsp_tready) |=> !rsp_tvalid)
      else $error("result after palette clear");

endmodule

bind clamped_line_raster_with_palette_core clr_checker u_clr_checker (.*);
